[src/c3mb_pkg.sv]
// Package for the 3x3 mirrored-border convolution unit.
// Shared constants and types; no dependencies.
`default_nettype none
package c3mb_pkg;
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 4096;
  localparam int PixW   = 16;
  localparam int CoefW  = 16;
  localparam int ValW   = 35;
  localparam int RowW   = 12;
  localparam int ColW   = 8;
  localparam int CfgW   = 48;
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKTop   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKMid   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKBot   = 3'd4;

  // One pending result: window snapshot plus mirror flags and tag
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic                 top_ref;
    logic                 bot_ref;
    logic                 left_ref;
    logic                 right_ref;
    logic [RowW-1:0]      row;
    logic [ColW-1:0]      col;
    logic                 last;
  } job_t;
endpackage
`default_nettype wire

[src/c3mb_mac.sv]
// Convolution arithmetic: nine products, registered, then one registered sum.
// Depends on c3mb_pkg.
`default_nettype none
module c3mb_mac import c3mb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire job_t                 in_job,
  input  wire logic [3*CfgW-1:0]    kern,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [ValW-1:0]    out_value,
  output logic [RowW-1:0]           out_row,
  output logic [ColW-1:0]           out_col,
  output logic                      out_last
);
  logic signed [31:0] prod_r [9];
  logic [RowW-1:0] row1_r;
  logic [ColW-1:0] col1_r;
  logic last1_r, v1_r, v2_r;
  logic adv1, adv2;
  logic signed [ValW-1:0] sum;

  assign adv2 = !v2_r || out_ready;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;

  // Stage 1: products, with the mirrored neighbour chosen per position
  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          logic [1:0] ra, cb;
          logic [3:0] wi;
          logic zero;
          logic signed [PixW-1:0] p;
          logic signed [CoefW-1:0] k;
          ra = a[1:0];
          cb = b[1:0];
          // Top mirror reads row 2 in place of row 0
          if (a == 0 && in_job.top_ref) ra = 2'd2;
          // Last row: centre on window row 2, mirror row 1 below it
          if (in_job.bot_ref) ra = (a == 2) ? 2'd1 : 2'(a + 1);
          if (b == 0 && in_job.left_ref) cb = 2'd2;
          if (in_job.right_ref) cb = (b == 2) ? 2'd1 : 2'(b + 1);
          zero = ((a == 0 && in_job.top_ref) || (a == 2 && in_job.bot_ref)) &&
                 ((b == 0 && in_job.left_ref) || (b == 2 && in_job.right_ref));
          wi = 4'(ra) * 4'd3 + 4'(cb);
          p = in_job.win[wi];
          k = kern[(2-a)*CfgW + (2-b)*CoefW +: CoefW];
          prod_r[a*3+b] <= zero ? 32'sd0 : p * k;
        end
      end
      row1_r  <= in_job.row;
      col1_r  <= in_job.col;
      last1_r <= in_job.last;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) sum = sum + ValW'(prod_r[i]);
  end

  // Stage 2: sum into the output register
  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      out_value <= sum;
      out_row   <= row1_r;
      out_col   <= col1_r;
      out_last  <= last1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end
  assign out_valid = v2_r;
endmodule
`default_nettype wire

[src/conv3x3_mirror_border_unit.sv]
// Top level: line-buffer memory, window, result sequencer and MAC pipeline.
// Depends on c3mb_pkg and c3mb_mac.
//
//  channel | ports                                   | handshake
//  in      | in_pixel_value                          | in_valid/in_ready
//  out     | out_value,out_row,out_col,out_last_of_item | out_valid/out_ready
//  cfg     | cfg_we,cfg_index,cfg_wdata              | write enable
//
// A pixel is read from the line memory at the edge that accepts it and its
// shifted pair is written back in the next cycle, forwarded to a read of the
// same entry. The window shifts when the staged pixel is taken; results then
// enter the two-stage MAC one per cycle while it accepts them, passing its
// product and output registers. A pixel causing results holds the window
// stage until its last result is taken; an output stall backs up through
// the MAC into in_ready. Reset is synchronous and clears counters, window and
// kernel, and sets the geometry to 256 by 256; line memory is not cleared.
`default_nettype none
module conv3x3_mirror_border_unit import c3mb_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [PixW-1:0] in_pixel_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [ValW-1:0]    out_value,
  output logic [RowW-1:0]           out_row,
  output logic [ColW-1:0]           out_col,
  output logic                      out_last_of_item,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgW-1:0]      cfg_wdata
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);

  logic [8:0]  width_r;
  logic [12:0] height_r;
  logic [3*CfgW-1:0] kern_r;
  logic [XW-1:0] w_eff, x_r, xc;
  logic [YW-1:0] h_eff, y_r, yc;
  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_r;
  logic [PixW-1:0] pix_r;
  logic [8:0][PixW-1:0] win_r;
  logic s1_r, wr_pend_r;
  logic [XW-1:0] x1_r;
  logic [YW-1:0] y1_r;
  logic [XW-1:0] w1_r;
  logic [YW-1:0] h1_r;
  logic a_emit, a_lc, a_lr;
  logic busy_r, busy_nxt, lc_r, lr_r, top_r, left_r;
  logic [RowW-1:0] row_r;
  logic [ColW-1:0] col_r;
  logic [1:0] seq_r, seq_nxt, last_idx;
  logic job_valid, job_ready, job_last, take;
  job_t job;
  logic in_fire;

  // Clamp geometry
  always_comb begin
    if (width_r < 9'd2) w_eff = XW'(2);
    else if (32'(width_r) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(width_r);
    if (height_r < 13'd2) h_eff = YW'(2);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(height_r);
    xc = (x_r >= w_eff) ? w_eff - 1'b1 : x_r;
    yc = (y_r >= h_eff) ? h_eff - 1'b1 : y_r;
  end

  // Position flags of the staged pixel
  always_comb begin
    a_emit = (x1_r != '0) && (y1_r != '0);
    a_lc   = (x1_r == w1_r - 1'b1);
    a_lr   = (y1_r == h1_r - 1'b1);
  end

  // Stage moves on when the window is free or sends its last result now
  assign last_idx = lc_r ? {lr_r, 1'b1} : {1'b0, lr_r};
  assign job_last = (seq_r == last_idx);
  assign take     = s1_r && (!busy_r || (job_ready && job_last));
  assign in_ready = !s1_r || take;
  assign in_fire  = in_valid && in_ready;

  // Config and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 9'd256; height_r <= 13'd256; kern_r <= '0;
      x_r <= '0; y_r <= '0;
    end else begin
      if (cfg_we && (cfg_index == RegWidth || cfg_index == RegHeight)) begin
        x_r <= '0;
        y_r <= '0;
      end else if (in_fire) begin
        if (xc + 1'b1 >= w_eff) begin
          x_r <= '0;
          y_r <= (yc + 1'b1 >= h_eff) ? '0 : yc + 1'b1;
        end else begin
          x_r <= xc + 1'b1;
          y_r <= yc;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          RegWidth:  width_r  <= cfg_wdata[8:0];
          RegHeight: height_r <= cfg_wdata[12:0];
          RegKTop:   kern_r[0*CfgW +: CfgW] <= cfg_wdata;
          RegKMid:   kern_r[1*CfgW +: CfgW] <= cfg_wdata;
          RegKBot:   kern_r[2*CfgW +: CfgW] <= cfg_wdata;
          default:   ;
        endcase
      end
    end
  end

  // Line memory: registered read on accept, shifted pair written back next cycle
  always_ff @(posedge clk) begin
    if (wr_pend_r) line_mem[x1_r[AW-1:0]] <= {rd_r[PixW-1:0], pix_r};
    if (in_fire) begin
      if (wr_pend_r && x1_r == xc) rd_r <= {rd_r[PixW-1:0], pix_r};
      else rd_r <= line_mem[xc[AW-1:0]];
      pix_r <= in_pixel_value;
      x1_r <= xc; y1_r <= yc; w1_r <= w_eff; h1_r <= h_eff;
    end
  end

  // Advance the result counter; reload it when a new pixel enters the window
  always_comb begin
    busy_nxt = busy_r;
    seq_nxt  = seq_r;
    if (busy_r && job_ready) begin
      seq_nxt = seq_r + 1'b1;
      if (job_last) busy_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt = a_emit;
      seq_nxt  = '0;
    end
  end

  // Window shift as the staged pixel moves in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0; s1_r <= 1'b0; wr_pend_r <= 1'b0; busy_r <= 1'b0; seq_r <= '0;
      lc_r <= 1'b0; lr_r <= 1'b0; top_r <= 1'b0; left_r <= 1'b0;
      row_r <= '0; col_r <= '0;
    end else begin
      wr_pend_r <= in_fire;
      s1_r <= in_fire || (s1_r && !take);
      busy_r <= busy_nxt;
      seq_r <= seq_nxt;
      if (take) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3+0] <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= rd_r[2*PixW-1:PixW];
        win_r[5] <= rd_r[PixW-1:0];
        win_r[8] <= pix_r;
        lc_r   <= a_lc;
        lr_r   <= a_lr;
        top_r  <= (y1_r == YW'(1));
        left_r <= (x1_r == XW'(1));
        row_r  <= RowW'(y1_r);
        col_r  <= ColW'(x1_r);
      end
    end
  end

  // Sequence the results of the window
  always_comb begin
    logic pass1, colr;
    pass1 = lc_r ? seq_r[1] : seq_r[0];
    colr  = lc_r && seq_r[0];
    job.win = win_r;
    job.top_ref   = !pass1 && top_r;
    job.bot_ref   = pass1;
    job.left_ref  = !colr && left_r;
    job.right_ref = colr;
    job.row  = pass1 ? row_r : row_r - 1'b1;
    job.col  = colr ? col_r : col_r - 1'b1;
    job.last = job_last;
  end
  assign job_valid = busy_r;

  c3mb_mac u_mac (
    .clk(clk), .rst_n(rst_n),
    .in_valid(job_valid), .in_ready(job_ready), .in_job(job), .kern(kern_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_row(out_row), .out_col(out_col), .out_last(out_last_of_item)
  );

  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> seq_r <= last_idx)
    else $error("sequencer overrun");
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> s1_r)
    else $error("accepted item not staged");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (s1_r && !take) |=> (s1_r && $stable(pix_r)))
    else $error("staged item lost");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("result dropped while stalled");
endmodule
`default_nettype wire
